// ===== sv/complex_magnitude_ratio_top_assert.svh =====
// Assertion macros for the complex magnitude ratio block.
`ifndef COMPLEX_MAGNITUDE_RATIO_TOP_ASSERT_SVH
`define COMPLEX_MAGNITUDE_RATIO_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define CMR_ASSERT_IMPL(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define CMR_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define CMR_ASSERT_IMPL(label, prop, msg)
`define CMR_ASSERT_NEVER(label, cond, msg)
`endif
`endif

// ===== sv/cmr_pkg.sv =====
// Package for the complex magnitude ratio block: widths and constants.
`timescale 1ns / 1ps
`default_nettype none
package cmr_pkg;
  localparam int unsigned InW    = 18;
  localparam int unsigned SqW    = 36;
  localparam int unsigned MultW  = 32;
  localparam int unsigned M2W    = 64;
  localparam int unsigned ProdW  = 100;
  localparam int unsigned QW     = 96;
  localparam int unsigned MagW   = 48;
  localparam int unsigned MultRst = 32'h0001_0000;
  localparam int unsigned AddrW  = 2;
  localparam logic [AddrW-1:0] RegScale = 2'd0;

  typedef struct packed {
    logic dz;
    logic sat;
  } flags_t;
endpackage
`default_nettype wire

// ===== sv/cmr_stage.sv =====
// One stage of a restoring divide or square root pipeline with payload.
`timescale 1ns / 1ps
`default_nettype none
module cmr_stage #(
  parameter int unsigned W = 8
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         en_i,
  input  wire logic         vld_i,
  input  wire logic [W-1:0] d_i,
  output logic              vld_o,
  output logic [W-1:0]      d_o
);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_o <= 1'b0;
    end else if (en_i) begin
      vld_o <= vld_i;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_o <= d_i;
    end
  end
endmodule
`default_nettype wire

// ===== sv/complex_magnitude_ratio_top.sv =====
// Scaled complex magnitude ratio, pipelined: squares, product, divide, root.
// Throughput: one transfer per cycle; divide is one quotient bit per stage,
// root one result bit per stage, all stages advance together when the output is empty or ready.
// Reset: asynchronous active low clears valid bits; multiplier resets to 1.0.
`timescale 1ns / 1ps
`default_nettype none
`include "complex_magnitude_ratio_top_assert.svh"
module complex_magnitude_ratio_top #(
  parameter int unsigned MultReset = cmr_pkg::MultRst
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // num_real[17:0], num_imag[35:18], den_real[53:36], den_imag[71:54]
  input  wire logic [71:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // magnitude[47:0]
  output logic [47:0]      m_axis_tdata,
  // divide_by_zero[0], saturated[1]
  output logic [1:0]       m_axis_tuser,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [cmr_pkg::AddrW-1:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  localparam int unsigned QW = cmr_pkg::QW;
  localparam int unsigned DW = cmr_pkg::SqW;
  localparam int unsigned PW = cmr_pkg::ProdW;
  localparam int unsigned MW = cmr_pkg::MagW;

  logic [31:0] mult_q;
  assign pready = 1'b1;
  assign prdata = (paddr == cmr_pkg::RegScale) ? mult_q : 32'd0;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mult_q <= MultReset[31:0];
    end else if (psel && penable && pwrite && paddr == cmr_pkg::RegScale) begin
      mult_q <= pwdata;
    end
  end

  // Global stall: whole pipe advances when the output can move.
  logic en;
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // Front end, 5 stages.
  logic [4:0] v_q;
  logic signed [17:0] nr_q, ni_q, dr_q, di_q;
  logic [35:0] nr2_q, ni2_q, dr2_q, di2_q, nsq_q, dsq_q, dsq3_q, dsq4_q;
  logic [63:0] m2_q, m2b_q;
  logic [31:0] ml_q;
  logic [67:0] lo_q, hi_q;
  logic [99:0] p_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[3:0], s_axis_tvalid};
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      nr_q <= s_axis_tdata[17:0];
      ni_q <= s_axis_tdata[35:18];
      dr_q <= s_axis_tdata[53:36];
      di_q <= s_axis_tdata[71:54];
      ml_q <= mult_q;
      nr2_q <= 36'($signed(nr_q) * $signed(nr_q));
      ni2_q <= 36'($signed(ni_q) * $signed(ni_q));
      dr2_q <= 36'($signed(dr_q) * $signed(dr_q));
      di2_q <= 36'($signed(di_q) * $signed(di_q));
      m2_q  <= 64'(ml_q) * 64'(ml_q);
      nsq_q <= nr2_q + ni2_q;
      dsq_q <= dr2_q + di2_q;
      m2b_q <= m2_q;
      lo_q  <= 68'(m2b_q[31:0]) * 68'(nsq_q);
      hi_q  <= 68'(m2b_q[63:32]) * 68'(nsq_q);
      dsq3_q <= dsq_q;
      p_q   <= 100'(lo_q) + (100'(hi_q) << 32);
      dsq4_q <= dsq3_q;
    end
  end

  // Divider: PW stages, one quotient bit each. Payload {rem, num, dsq}.
  localparam int unsigned RW = DW + 1;
  localparam int unsigned DVW = RW + PW + DW;
  logic [DVW-1:0] dv_d [PW+1];
  logic [PW:0]    dv_v;
  assign dv_d[0] = {RW'(0), p_q, dsq4_q};
  assign dv_v[0] = v_q[4];
  for (genvar i = 0; i < PW; i++) begin : g_div
    logic [RW-1:0] r, rs;
    logic [PW-1:0] n;
    logic [DW-1:0] d;
    logic [DVW-1:0] nx;
    always_comb begin
      {r, n, d} = dv_d[i];
      rs = {r[RW-2:0], n[PW-1]};
      if (rs >= RW'(d) && d != '0) begin
        nx = {rs - RW'(d), n[PW-2:0], 1'b1, d};
      end else begin
        nx = {rs, n[PW-2:0], 1'b0, d};
      end
    end
    cmr_stage #(.W(DVW)) u_st (.clk_i, .rst_ni, .en_i(en), .vld_i(dv_v[i]),
      .d_i(nx), .vld_o(dv_v[i+1]), .d_o(dv_d[i+1]));
  end

  logic [PW-1:0] quo;
  logic [DW-1:0] dfin;
  assign quo  = dv_d[PW][PW+DW-1:DW];
  assign dfin = dv_d[PW][DW-1:0];

  // Root: MW stages, one result bit each. Payload {rem, q, root, dz, sat}.
  localparam int unsigned SRW = MW + 2;
  localparam int unsigned SQW = SRW + QW + MW + 2;
  logic [SQW-1:0] sq_d [MW+1];
  logic [MW:0]    sq_v;
  assign sq_d[0] = {SRW'(0), quo[QW-1:0], MW'(0), (dfin == '0), (quo[PW-1:QW] != '0)};
  assign sq_v[0] = dv_v[PW];
  for (genvar j = 0; j < MW; j++) begin : g_sqrt
    logic [SRW-1:0] r, rs, t;
    logic [QW-1:0] q;
    logic [MW-1:0] rt;
    logic dz, st;
    logic [SQW-1:0] nx;
    always_comb begin
      {r, q, rt, dz, st} = sq_d[j];
      rs = {r[SRW-3:0], q[QW-1:QW-2]};
      t  = {rt, 2'b01};
      if (rs >= t) begin
        nx = {rs - t, q[QW-3:0], 2'b00, rt[MW-2:0], 1'b1, dz, st};
      end else begin
        nx = {rs, q[QW-3:0], 2'b00, rt[MW-2:0], 1'b0, dz, st};
      end
    end
    cmr_stage #(.W(SQW)) u_st (.clk_i, .rst_ni, .en_i(en), .vld_i(sq_v[j]),
      .d_i(nx), .vld_o(sq_v[j+1]), .d_o(sq_d[j+1]));
  end

  cmr_pkg::flags_t fl;
  logic [MW-1:0] root;
  assign root = sq_d[MW][MW+1:2];
  assign fl.dz  = sq_d[MW][1];
  assign fl.sat = sq_d[MW][0] && !sq_d[MW][1];

  assign m_axis_tvalid = sq_v[MW];
  assign m_axis_tdata  = (fl.dz || fl.sat) ? {MW{1'b1}} : root;
  assign m_axis_tuser  = {fl.sat, fl.dz};

  `CMR_ASSERT_NEVER(a_flags_excl, m_axis_tvalid && m_axis_tuser[0] && m_axis_tuser[1],
    "both flags set")
  `CMR_ASSERT_IMPL(a_stall_hold, (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid,
    "result lost under stall")
  `CMR_ASSERT_IMPL(a_flag_ones, (m_axis_tvalid && m_axis_tuser != 2'b00)
    |-> (m_axis_tdata == {MW{1'b1}}), "flagged result not all ones")
endmodule
`default_nettype wire
